### src/lsc_pkg.sv
// shared types, codes and helpers for the segment level-of-detail classifier
package lsc_pkg;

    localparam int LSC_FRAC_BITS = 16;

    localparam int COORD_W = 32;
    localparam int RAD_W   = 64;
    localparam int ACC_W   = 40;
    localparam int GAP_W   = 34;
    localparam int CFG_IDX_W = 3;

    localparam logic [1:0] MODE_EXTRUDE = 2'd0;
    localparam logic [1:0] MODE_LINE    = 2'd1;
    localparam logic [1:0] MODE_NONE    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FAR      = 3'd4;

    typedef struct packed {
        logic                done;
        logic [COORD_W-1:0]  distance;
    } t_dist_rsp;

    // can the current run take a segment, given the length summed so far
    function automatic logic run_admits(
        input logic [1:0]       mode,
        input logic [ACC_W-1:0] acc,
        input logic [GAP_W-1:0] near_gap,
        input logic [GAP_W-1:0] far_gap
    );
        logic lt_near;
        logic lt_far;
        lt_near = acc < {{(ACC_W-GAP_W){1'b0}}, near_gap};
        lt_far  = acc < {{(ACC_W-GAP_W){1'b0}}, far_gap};
        case (mode)
            MODE_EXTRUDE: run_admits = lt_near;
            MODE_LINE:    run_admits = lt_near && lt_far;
            default:      run_admits = lt_far;
        endcase
    endfunction

endpackage

### src/lsc_dist_unit.sv
// camera distance: one shared multiplier for the squares, then a bit-serial square root
module lsc_dist_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [lsc_pkg::COORD_W-1:0]   i_cam_x,
    input  logic [lsc_pkg::COORD_W-1:0]   i_cam_y,
    input  logic [lsc_pkg::COORD_W-1:0]   i_cam_z,
    input  logic [lsc_pkg::COORD_W-1:0]   i_pt_x,
    input  logic [lsc_pkg::COORD_W-1:0]   i_pt_y,
    input  logic [lsc_pkg::COORD_W-1:0]   i_pt_z,
    output lsc_pkg::t_dist_rsp            o_rsp
);
    import lsc_pkg::*;

    typedef enum logic [2:0] {
        D_IDLE = 3'b001,
        D_SQ   = 3'b010,
        D_ROOT = 3'b100
    } t_dstate;

    localparam int MAG_W = COORD_W + 1;
    localparam int REM_W = COORD_W + 1;

    t_dstate              r_state;
    logic [4:0]           r_cnt;
    logic [MAG_W-1:0]     r_mag_x, r_mag_y, r_mag_z;
    logic [RAD_W-1:0]     r_prod;
    logic                 r_psat;
    logic [RAD_W-1:0]     r_acc;
    logic [REM_W-1:0]     r_rem;
    logic [COORD_W-1:0]   r_root;
    logic                 r_done;

    logic [MAG_W-1:0]     mag_sel;
    logic [RAD_W:0]       sum;
    logic [RAD_W-1:0]     sum_sat;
    logic [REM_W+1:0]     rem2;
    logic [REM_W+1:0]     trial;
    logic                 take;

    function automatic logic [MAG_W-1:0] abs_diff(
        input logic [COORD_W-1:0] a,
        input logic [COORD_W-1:0] b
    );
        logic [MAG_W-1:0] d;
        d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        abs_diff = d[MAG_W-1] ? (~d + MAG_W'(1)) : d;
    endfunction

    always_comb begin
        case (r_cnt[1:0])
            2'd0:    mag_sel = r_mag_x;
            2'd1:    mag_sel = r_mag_y;
            default: mag_sel = r_mag_z;
        endcase
    end

    // saturating add of the previous square
    assign sum     = {1'b0, r_acc} + {1'b0, r_prod};
    assign sum_sat = (r_psat || sum[RAD_W]) ? {RAD_W{1'b1}} : sum[RAD_W-1:0];

    // one root digit: bring down two radicand bits, try (root*4 + 1)
    assign rem2  = {r_rem, r_acc[RAD_W-1 -: 2]};
    assign trial = {1'b0, r_root, 2'b01};
    assign take  = rem2 >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= (r_state == D_ROOT) && (r_cnt == 5'd31);
            case (r_state)
                D_IDLE: begin
                    if (i_start) begin
                        r_state <= D_SQ;
                        r_cnt   <= '0;
                    end
                end
                D_SQ: begin
                    if (r_cnt[1:0] == 2'd3) begin
                        r_state <= D_ROOT;
                        r_cnt   <= '0;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                D_ROOT: begin
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) begin
                        r_state <= D_IDLE;
                    end
                end
                default: r_state <= D_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            D_IDLE: begin
                r_mag_x <= abs_diff(i_cam_x, i_pt_x);
                r_mag_y <= abs_diff(i_cam_y, i_pt_y);
                r_mag_z <= abs_diff(i_cam_z, i_pt_z);
                r_acc   <= '0;
                r_prod  <= '0;
                r_psat  <= 1'b0;
            end
            D_SQ: begin
                if (r_cnt[1:0] != 2'd3) begin
                    r_prod <= {{COORD_W{1'b0}}, mag_sel[COORD_W-1:0]}
                            * {{COORD_W{1'b0}}, mag_sel[COORD_W-1:0]};
                    r_psat <= mag_sel[MAG_W-1];
                end
                r_acc  <= sum_sat;
                r_rem  <= '0;
                r_root <= '0;
            end
            D_ROOT: begin
                r_acc  <= {r_acc[RAD_W-3:0], 2'b00};
                r_rem  <= take ? REM_W'(rem2 - trial) : rem2[REM_W-1:0];
                r_root <= {r_root[COORD_W-2:0], take};
            end
            default: begin
            end
        endcase
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.distance = r_root;

endmodule

### src/lod_segment_classifier_unit.sv
// top level: run sequencer, mode classification and stream ports
//
//  channel   dir  handshake               payload
//  s_axis    in   tvalid/tready           tdata[127:0], tlast = final_segment
//  m_axis    out  tvalid/tready           tdata[7:0], tlast = last_out
//  cfg       in   i_cfg_we (no wait)      i_cfg_idx, i_cfg_data
//
//  a segment inside a running run goes S_CHECK, S_ADV, then into the output register;
//  a run start goes S_CHECK, S_START, S_DIST, S_ADV, where S_DIST does the squares
//  on one multiplier, then 32 root digits; s_axis takes no new segment until S_IDLE
//  reset is synchronous, active low; it clears run state and loads register defaults
//  the result sits in an output register, so a stalled m_axis only holds the last step
module lod_segment_classifier_unit #(
    parameter int FRAC_BITS = lsc_pkg::LSC_FRAC_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [lsc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lsc_pkg::COORD_W-1:0]    i_cfg_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // start_x, start_y, start_z, segment_length
    input  logic [127:0]                   s_axis_tdata,
    input  logic                           s_axis_tlast,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // segment_mode[1:0], run_start[2], zero fill
    output logic [7:0]                     m_axis_tdata,
    output logic                           m_axis_tlast
);
    import lsc_pkg::*;

    localparam logic [63:0] NEAR_RAW = 64'd1000 << FRAC_BITS;
    localparam logic [COORD_W-1:0] NEAR_RST =
        (NEAR_RAW > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : NEAR_RAW[COORD_W-1:0];
    localparam logic [COORD_W-1:0] FAR_RST = 32'd0 - (32'd1 << FRAC_BITS);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CHECK = 5'b00010,
        S_START = 5'b00100,
        S_DIST  = 5'b01000,
        S_ADV   = 5'b10000
    } t_state;

    t_state              r_state, n_state;
    logic [COORD_W-1:0]  r_cam_x, r_cam_y, r_cam_z, r_near, r_far;
    logic [COORD_W-1:0]  r_px, r_py, r_pz, r_len;
    logic                r_last;
    logic                r_run_active;
    logic [1:0]          r_run_mode;
    logic [ACC_W-1:0]    r_acc;
    logic [GAP_W-1:0]    r_near_gap, r_far_gap;
    logic                r_rs;
    logic                r_out_valid;
    logic [1:0]          r_out_mode;
    logic                r_out_rs;
    logic                r_out_last;

    t_dist_rsp           dist_rsp;
    logic                dist_start;
    logic                admits;
    logic                out_free;
    logic [GAP_W-1:0]    dist_s, near_s, far_s;
    logic [GAP_W-1:0]    d_near, d_far;
    logic                far_pos;
    logic [1:0]          new_mode;
    logic [ACC_W:0]      acc_sum;

    lsc_dist_unit u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (dist_start),
        .i_cam_x (r_cam_x),
        .i_cam_y (r_cam_y),
        .i_cam_z (r_cam_z),
        .i_pt_x  (r_px),
        .i_pt_y  (r_py),
        .i_pt_z  (r_pz),
        .o_rsp   (dist_rsp)
    );

    assign admits     = run_admits(r_run_mode, r_acc, r_near_gap, r_far_gap);
    assign out_free   = !r_out_valid || m_axis_tready;
    assign dist_start = (r_state == S_START);

    // classification of a fresh distance, all compares in 34-bit signed
    assign dist_s  = {2'b00, dist_rsp.distance};
    assign near_s  = {{(GAP_W-COORD_W){r_near[COORD_W-1]}}, r_near};
    assign far_s   = {{(GAP_W-COORD_W){r_far[COORD_W-1]}}, r_far};
    assign d_near  = dist_s - near_s;
    assign d_far   = dist_s - far_s;
    assign far_pos = !r_far[COORD_W-1] && (r_far != '0);

    always_comb begin
        if ($signed(dist_s) < $signed(near_s)) begin
            new_mode = MODE_EXTRUDE;
        end else if (far_pos) begin
            new_mode = ($signed(dist_s) < $signed(far_s)) ? MODE_LINE : MODE_NONE;
        end else begin
            new_mode = MODE_LINE;
        end
    end

    assign acc_sum = {1'b0, r_acc} + {{(ACC_W+1-COORD_W){1'b0}}, r_len};

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (s_axis_tvalid) n_state = S_CHECK;
            S_CHECK: n_state = (r_run_active && admits) ? S_ADV : S_START;
            S_START: n_state = S_DIST;
            S_DIST:  if (dist_rsp.done) n_state = S_ADV;
            S_ADV:   if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cam_x      <= '0;
            r_cam_y      <= '0;
            r_cam_z      <= '0;
            r_near       <= NEAR_RST;
            r_far        <= FAR_RST;
            r_run_active <= 1'b0;
            r_run_mode   <= MODE_EXTRUDE;
            r_acc        <= '0;
            r_near_gap   <= '0;
            r_far_gap    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CAMERA_X: r_cam_x <= i_cfg_data;
                    CFG_CAMERA_Y: r_cam_y <= i_cfg_data;
                    CFG_CAMERA_Z: r_cam_z <= i_cfg_data;
                    CFG_NEAR:     r_near  <= i_cfg_data;
                    CFG_FAR:      r_far   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (r_state == S_ADV && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CHECK: begin
                    if (!(r_run_active && admits)) begin
                        r_run_active <= 1'b0;
                    end
                end
                S_DIST: begin
                    if (dist_rsp.done) begin
                        r_run_mode   <= new_mode;
                        r_near_gap   <= d_near[GAP_W-1] ? (~d_near + GAP_W'(1)) : d_near;
                        r_far_gap    <= d_far[GAP_W-1] ? (~d_far + GAP_W'(1)) : d_far;
                        r_acc        <= '0;
                        r_run_active <= 1'b1;
                    end
                end
                S_ADV: begin
                    if (out_free) begin
                        // end of spine: run state back to reset
                        if (r_last) begin
                            r_run_active <= 1'b0;
                            r_run_mode   <= MODE_EXTRUDE;
                            r_acc        <= '0;
                            r_near_gap   <= '0;
                            r_far_gap    <= '0;
                        end else if (admits) begin
                            r_acc <= acc_sum[ACC_W] ? {ACC_W{1'b1}} : acc_sum[ACC_W-1:0];
                        end else begin
                            r_run_active <= 1'b0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && s_axis_tvalid) begin
            r_px   <= s_axis_tdata[31:0];
            r_py   <= s_axis_tdata[63:32];
            r_pz   <= s_axis_tdata[95:64];
            r_len  <= s_axis_tdata[127:96];
            r_last <= s_axis_tlast;
        end
        if (r_state == S_CHECK) begin
            r_rs <= !(r_run_active && admits);
        end
        if (r_state == S_ADV && out_free) begin
            r_out_mode <= admits ? r_run_mode : MODE_NONE;
            r_out_rs   <= r_rs;
            r_out_last <= r_last;
        end
    end

    assign s_axis_tready = i_rst_n && (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b00000, r_out_rs, r_out_mode};
    assign m_axis_tlast  = r_out_last;

endmodule

### test/lod_segment_classifier_unit_tb.sv
// self-checking stream testbench for the segment level-of-detail classifier
module lod_segment_classifier_unit_tb;

    import lsc_pkg::*;

    localparam int PERIOD      = 10;
    localparam int SETTLE      = 48;
    localparam int STALL_LIMIT = 2000;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic [31:0]               len;
        logic                      fin;
    } t_segment;

    typedef struct {
        logic [1:0] mode;
        logic       run_start;
        logic       last;
    } t_verdict;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx = '0;
    logic [COORD_W-1:0]     i_cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [127:0]           s_axis_tdata = '0;
    logic                   s_axis_tlast = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [7:0]             m_axis_tdata;
    logic                   m_axis_tlast;

    // classifier copy of the registers
    logic signed [COORD_W-1:0] cam_x = '0;
    logic signed [COORD_W-1:0] cam_y = '0;
    logic signed [COORD_W-1:0] cam_z = '0;
    logic signed [COORD_W-1:0] near_lim = 32'sd65536000;
    logic signed [COORD_W-1:0] far_lim = -32'sd65536;

    // classifier copy of the run state
    bit               run_live = 1'b0;
    logic [1:0]       run_kind = MODE_EXTRUDE;
    bit [ACC_W-1:0]   run_len_sum = '0;
    bit [GAP_W-1:0]   gap_to_near = '0;
    bit [GAP_W-1:0]   gap_to_far = '0;

    t_verdict    expected_verdicts[$];
    int unsigned err_count = 0;
    bit          steady = 1'b0;
    int unsigned reach = 1 << 20;
    int unsigned rx_hold = 0;

    lod_segment_classifier_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #(PERIOD/2) i_clk = ~i_clk;

    // ---------------------------------------------------------------- predictor

    function automatic bit [31:0] root_floor(bit [63:0] rad);
        bit [63:0] res;
        bit [63:0] one;
        res = '0;
        one = 64'h4000_0000_0000_0000;
        while (one > rad) one = one >> 2;
        while (one != 0) begin
            if (rad >= res + one) begin
                rad = rad - (res + one);
                res = (res >> 1) + one;
            end else begin
                res = res >> 1;
            end
            one = one >> 2;
        end
        return res[31:0];
    endfunction

    function automatic bit [63:0] square_mag(longint d);
        bit [63:0] mag;
        mag = (d < 0) ? 64'(-d) : 64'(d);
        return mag * mag;
    endfunction

    function automatic void open_run(t_segment s);
        bit [65:0] rad_sum;
        bit [63:0] rad;
        longint    cam_range;
        longint    nv;
        longint    fv;
        rad_sum = 66'(square_mag(longint'(cam_x) - longint'(s.x)))
                + 66'(square_mag(longint'(cam_y) - longint'(s.y)))
                + 66'(square_mag(longint'(cam_z) - longint'(s.z)));
        rad = (rad_sum[65:64] != 0) ? '1 : rad_sum[63:0];
        cam_range = longint'({32'b0, root_floor(rad)});
        nv = longint'(near_lim);
        fv = longint'(far_lim);
        if (cam_range < nv)
            run_kind = MODE_EXTRUDE;
        else if (fv > 0)
            run_kind = (cam_range < fv) ? MODE_LINE : MODE_NONE;
        else
            run_kind = MODE_LINE;
        gap_to_near = GAP_W'((cam_range >= nv) ? cam_range - nv : nv - cam_range);
        gap_to_far  = GAP_W'((cam_range >= fv) ? cam_range - fv : fv - cam_range);
        run_len_sum = '0;
        run_live = 1'b1;
    endfunction

    function automatic bit run_takes();
        bit lt_near;
        bit lt_far;
        lt_near = run_len_sum < ACC_W'(gap_to_near);
        lt_far  = run_len_sum < ACC_W'(gap_to_far);
        case (run_kind)
            MODE_EXTRUDE: return lt_near;
            MODE_LINE:    return lt_near && lt_far;
            default:      return lt_far;
        endcase
    endfunction

    function automatic t_verdict classify_segment(t_segment s);
        t_verdict     v;
        bit [ACC_W:0] sum;
        v.run_start = 1'b0;
        v.last = s.fin;
        if (run_live && !run_takes()) run_live = 1'b0;
        if (!run_live) begin
            open_run(s);
            v.run_start = 1'b1;
        end
        if (run_takes()) begin
            v.mode = run_kind;
            sum = (ACC_W+1)'(run_len_sum) + (ACC_W+1)'(s.len);
            run_len_sum = sum[ACC_W] ? '1 : sum[ACC_W-1:0];
        end else begin
            v.mode = MODE_NONE;
            run_live = 1'b0;
        end
        if (s.fin) begin
            run_live = 1'b0;
            run_kind = MODE_EXTRUDE;
            run_len_sum = '0;
            gap_to_near = '0;
            gap_to_far = '0;
        end
        return v;
    endfunction

    // ---------------------------------------------------------------- drivers

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_CAMERA_X: cam_x = data;
            CFG_CAMERA_Y: cam_y = data;
            CFG_CAMERA_Z: cam_z = data;
            CFG_NEAR:     near_lim = data;
            CFG_FAR:      far_lim = data;
            default:      ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_config(input logic [31:0] cx, input logic [31:0] cy,
                                input logic [31:0] cz, input logic [31:0] nr,
                                input logic [31:0] fr);
        write_reg(CFG_CAMERA_X, cx);
        write_reg(CFG_CAMERA_Y, cy);
        write_reg(CFG_CAMERA_Z, cz);
        write_reg(CFG_NEAR, nr);
        write_reg(CFG_FAR, fr);
    endtask

    task automatic send_segment(input logic [31:0] x, input logic [31:0] y,
                                input logic [31:0] z, input logic [31:0] len,
                                input logic fin);
        t_segment s;
        s.x = x;
        s.y = y;
        s.z = z;
        s.len = len;
        s.fin = fin;
        if (!steady && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        s_axis_tdata  <= {len, z, y, x};
        s_axis_tlast  <= fin;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        expected_verdicts.push_back(classify_segment(s));
    endtask

    // stop sending and let every outstanding result come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_verdicts.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic logic [31:0] around(logic [31:0] c);
        return c + $urandom_range(0, 2 * reach) - reach;
    endfunction

    // spines of points around the camera, with some unrelated noise segments
    task automatic send_spines(input int unsigned count);
        int unsigned sent;
        int unsigned spine_len;
        int unsigned k;
        logic [31:0] len;
        logic        fin;
        sent = 0;
        while (sent < count) begin
            spine_len = $urandom_range(1, 24);
            for (k = 0; k < spine_len && sent < count; k++) begin
                if (k == spine_len - 1)
                    fin = ($urandom_range(0, 7) != 0);
                else
                    fin = ($urandom_range(0, 19) == 0);
                case ($urandom_range(0, 15))
                    0:       len = $urandom;
                    1:       len = '0;
                    default: len = $urandom_range(0, reach);
                endcase
                if ($urandom_range(0, 9) == 0)
                    send_segment($urandom, $urandom, $urandom, $urandom,
                                 1'($urandom_range(0, 1)));
                else
                    send_segment(around(cam_x), around(cam_y), around(cam_z), len, fin);
                sent++;
            end
        end
    endtask

    task automatic random_config();
        logic [31:0] nr;
        logic [31:0] fr;
        reach = 1 << $urandom_range(12, 26);
        nr = $urandom_range(0, 2 * reach);
        case ($urandom_range(0, 2))
            0:       fr = ($urandom_range(0, 1) != 0) ? 32'd0 : (32'h8000_0000 | $urandom);
            default: fr = nr + $urandom_range(0, 2 * reach);
        endcase
        if ($urandom_range(0, 3) == 0)
            write_config($urandom, $urandom, $urandom, nr, fr);
        else
            write_config($urandom_range(0, 1 << 24) - (1 << 23),
                         $urandom_range(0, 1 << 24) - (1 << 23),
                         $urandom_range(0, 1 << 24) - (1 << 23), nr, fr);
    endtask

    // ---------------------------------------------------------------- response side

    always @(posedge i_clk) begin
        if (rx_hold != 0) begin
            rx_hold <= rx_hold - 1;
        end else if (!steady && $urandom_range(0, 9) == 0) begin
            m_axis_tready <= 1'b0;
            rx_hold <= $urandom_range(0, 13);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_verdict want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_verdicts.size() == 0) begin
                $display("%0t: unexpected result transfer, expected none, actual tdata %h",
                         $time, m_axis_tdata);
                err_count++;
            end else begin
                want = expected_verdicts.pop_front();
                if (m_axis_tdata[1:0] !== want.mode) begin
                    $display("%0t: segment_mode mismatch, expected %0d, actual %0d",
                             $time, want.mode, m_axis_tdata[1:0]);
                    err_count++;
                end
                if (m_axis_tdata[2] !== want.run_start) begin
                    $display("%0t: run_start mismatch, expected %0d, actual %0d",
                             $time, want.run_start, m_axis_tdata[2]);
                    err_count++;
                end
                if (m_axis_tlast !== want.last) begin
                    $display("%0t: last_out mismatch, expected %0d, actual %0d",
                             $time, want.last, m_axis_tlast);
                    err_count++;
                end
            end
        end
    end

    initial begin : watchdog
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    // ---------------------------------------------------------------- tests

    task automatic test_directed_cases();
        // default registers: origin, extremes of the point and length fields
        send_segment(32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
        send_segment(32'h0, 32'h0, 32'h0, 32'h1, 1'b0);
        send_segment(32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 1'b1);
        send_segment(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_segment(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0, 1'b1);
        drain();
        // radicand saturates, distance pins at full scale
        write_config(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000);
        send_segment(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h1234, 1'b1);
        drain();
        // distance equal to near: line run with zero gap is skipped
        write_config(32'h0, 32'h0, 32'h0, 32'h0003_0000, 32'hFFFF_0000);
        send_segment(32'h0003_0000, 32'h0, 32'h0, 32'h5, 1'b0);
        send_segment(32'h0, 32'h0, 32'h0, 32'h5, 1'b0);
        send_segment(32'h0, 32'h0, 32'h0, 32'h0002_0000, 1'b1);
        drain();
        // beyond far: nothing drawn, restart when far gap is used up
        write_reg(CFG_NEAR, 32'h0001_0000);
        write_reg(CFG_FAR, 32'h0002_0000);
        send_segment(32'h0003_0000, 32'h0, 32'h0, 32'h0002_0000, 1'b0);
        send_segment(32'h0003_0000, 32'h0, 32'h0, 32'h1, 1'b0);
        send_segment(32'h0002_0000, 32'h0, 32'h0, 32'h1, 1'b1);
        // distance equal to far: skipped
        send_segment(32'h0, 32'h0002_0000, 32'h0, 32'h7, 1'b0);
        // between near and far: line, limited by both gaps
        send_segment(32'h0, 32'h0, 32'h0001_8000, 32'h8000, 1'b0);
        send_segment(32'h0, 32'h0, 32'h0001_8000, 32'h0, 1'b1);
        drain();
        write_reg(CFG_NEAR, 32'h8000_0000);
        write_reg(CFG_FAR, 32'h0);
        send_segment(32'h1234_5678, 32'hEDCB_A987, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 1'b0);
        send_segment(32'h0, 32'h0, 32'h0, 32'h0, 1'b1);
        drain();
        write_reg(CFG_NEAR, 32'h7FFF_FFFF);
        write_reg(CFG_FAR, 32'h7FFF_FFFF);
        send_segment(32'h7FFF_FFFF, 32'h0, 32'h0, 32'hAAAA_AAAA, 1'b0);
        send_segment(32'h0, 32'h0, 32'h0, 32'h5555_5555, 1'b0);
        drain();
        write_reg(CFG_FAR, 32'h8000_0000);
        send_segment(32'h0, 32'h0, 32'h8000_0000, 32'h0, 1'b0);
        drain();
        // indexes past the register list leave everything unchanged
        write_reg(3'd5, $urandom);
        write_reg(3'd6, $urandom);
        write_reg(3'd7, $urandom);
        send_segment(32'h0001_0000, 32'h0, 32'h0, 32'h10, 1'b1);
        drain();
    endtask

    task automatic test_register_extremes();
        int unsigned k;
        reach = 1 << 24;
        for (k = 0; k < 6; k++) begin
            case (k)
                0: write_config(32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
                1: write_config(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF);
                2: write_config(32'h0, 32'h0, 32'h0, 32'h0, 32'h8000_0000);
                3: write_config(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h1);
                4: write_config(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                32'h0100_0000, 32'h0200_0000);
                default: write_config(32'h0, 32'h0, 32'h0, 32'h03E8_0000, 32'hFFFF_0000);
            endcase
            send_spines(20);
            drain();
        end
    endtask

    task automatic test_random_spines();
        int unsigned phase;
        for (phase = 0; phase < 8; phase++) begin
            random_config();
            // every other phase runs without any idling
            steady = phase[0];
            send_spines(100);
            drain();
        end
        steady = 1'b0;
    endtask

    task automatic test_steady_tail();
        random_config();
        steady = 1'b1;
        send_spines(100);
        drain();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_register_extremes();
        test_random_spines();
        test_steady_tail();
        if (err_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
